FILE: hw/rtl/svga_extended_register_banking_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extended register banking block
// Shared clocked assertion forms with a reset disable.
// ----------------------------------------------------------------------------
`ifndef SVGA_EXTENDED_REGISTER_BANKING_MACROS_SVH
`define SVGA_EXTENDED_REGISTER_BANKING_MACROS_SVH

// Clocked assertion, explicit clock and active-low reset.
`define SVGAERB_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion on clk_i / rst_ni.
`define SVGAERB_ASSERT(lbl, prop, msg) \
  `SVGAERB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/svgaerb_pkg.sv
// ----------------------------------------------------------------------------
// svgaerb_pkg
// Port numbers, register indexes, CRTC write masks and chip ids.
// ----------------------------------------------------------------------------
package svgaerb_pkg;

  localparam int unsigned CrtcDepth = 64;
  localparam int unsigned CrtcIdxW  = $clog2(CrtcDepth);

  // I/O ports after the mono/color swap
  localparam logic [9:0] PortMiscW  = 10'h3C2;
  localparam logic [9:0] PortMiscR  = 10'h3CC;
  localparam logic [9:0] PortSeqIdx = 10'h3C4;
  localparam logic [9:0] PortSeqDat = 10'h3C5;
  localparam logic [9:0] PortGfxIdx = 10'h3CE;
  localparam logic [9:0] PortGfxDat = 10'h3CF;
  localparam logic [9:0] PortCrtIdx = 10'h3D4;
  localparam logic [9:0] PortCrtDat = 10'h3D5;
  localparam logic [9:0] PortWrBank = 10'h3D8;
  localparam logic [9:0] PortRdBank = 10'h3D9;
  localparam logic [9:0] PortClkSel = 10'h3DB;

  localparam logic [5:0] PortMonoHi  = 6'h3B;
  localparam logic [5:0] PortColorHi = 6'h3D;
  localparam logic [9:0] PortSwapXor = 10'h060;

  // Sequencer and graphics indexes
  localparam logic [3:0] SeqIdxVersion = 4'hB;
  localparam logic [3:0] SeqIdxCtrlTwo = 4'hD;
  localparam logic [3:0] SeqIdxCtrlOne = 4'hE;
  localparam logic [3:0] GfxIdxRegE    = 4'hE;
  localparam logic [3:0] GfxIdxRegF    = 4'hF;

  // CRTC indexes
  localparam logic [CrtcIdxW-1:0] CrtIdxOverflow = 6'h07;
  localparam logic [CrtcIdxW-1:0] CrtIdxPreset   = 6'h08;
  localparam logic [CrtcIdxW-1:0] CrtIdxStartHi  = 6'h0C;
  localparam logic [CrtcIdxW-1:0] CrtIdxStartLo  = 6'h0D;
  localparam logic [CrtcIdxW-1:0] CrtIdxCursorHi = 6'h0E;
  localparam logic [CrtcIdxW-1:0] CrtIdxVrsEnd   = 6'h11;
  localparam logic [CrtcIdxW-1:0] CrtIdxHoleLo   = 6'h19;
  localparam logic [CrtcIdxW-1:0] CrtIdxHoleHi   = 6'h1D;
  localparam logic [CrtcIdxW-1:0] CrtIdxModule   = 6'h1E;
  localparam logic [CrtcIdxW-1:0] CrtIdxVrsStart = 6'h10;

  // Chip model codes and their version ids
  localparam logic [1:0] ChipModelB   = 2'd0;
  localparam logic [1:0] ChipModelCld = 2'd1;
  localparam logic [1:0] ChipModelNew = 2'd2;
  localparam logic [7:0] ChipIdB      = 8'h03;
  localparam logic [7:0] ChipIdCld    = 8'h33;
  localparam logic [7:0] ChipIdNew    = 8'h23;

  localparam logic [7:0] ReadIdle = 8'hFF;

  localparam logic [7:0] CrtcWmask [CrtcDepth] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'h7f, 8'hff, 8'h3f, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'hff, 8'hff, 8'hef,
    8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff,
    8'h7f, 8'h00, 8'h00, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h03,
    8'h00, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] chip_id(input logic [1:0] model);
    logic [7:0] id;
    case (model)
      ChipModelB:   id = ChipIdB;
      ChipModelNew: id = ChipIdNew;
      default:      id = ChipIdCld;
    endcase
    return id;
  endfunction

endpackage

FILE: hw/rtl/svgaerb_ram.sv
// ----------------------------------------------------------------------------
// svgaerb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svgaerb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/svga_extended_register_banking.sv
// Path: a transfer accepted with start is held in the input register, passes the
// update logic and lands in the result register, which drives done_o.
// Throughput: one access per cycle; busy is never raised and results cannot stall.
// Reset: rst_ni clears state, pulses, done and CRTC valid bits at once, not input or
// data registers; chip model resets to 1. The CRTC file RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// svga_extended_register_banking
// I/O register file for extended banking: CRTC file, sequencer/graphics
// extensions, bank registers, start address and change pulses.
// ----------------------------------------------------------------------------
module svga_extended_register_banking
  import svgaerb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [9:0]  port_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic [4:0]  mem_wr_bank_o,
  output logic [4:0]  mem_rd_bank_o,
  output logic [16:0] start_address_o,
  output logic        full_memory_display_o,
  output logic        timing_changed_o,
  output logic        start_changed_o
);

  // Input register
  logic       item_vld_q;
  logic       op_q;
  logic [9:0] port_q;
  logic [7:0] wdat_q;

  // Architectural state
  logic [1:0]          chip_q;
  logic [7:0]          misc_q, misc_d;
  logic [3:0]          seq_idx_q, seq_idx_d;
  logic [3:0]          gfx_idx_q, gfx_idx_d;
  logic [7:0]          seq_mode_q, seq_mode_d;
  logic [7:0]          gfx_e_q, gfx_e_d;
  logic [7:0]          gfx_f_q, gfx_f_d;
  logic [CrtcIdxW-1:0] crt_idx_q, crt_idx_d;
  logic                legacy_q, legacy_d;
  logic [7:0]          lctl1_q, lctl1_d;
  logic [7:0]          lctl2_q, lctl2_d;
  logic [7:0]          nctl2_q, nctl2_d;
  logic [7:0]          wbank_q, wbank_d;
  logic [7:0]          rbank_q, rbank_d;
  logic [16:0]         start_q, start_d;

  // Shadow copies of CRTC entries read at fixed indexes
  logic [7:0] crt08_q, crt08_d;
  logic [7:0] crt0c_q, crt0c_d;
  logic [7:0] crt0d_q, crt0d_d;
  logic [7:0] crt11_q, crt11_d;
  logic [7:0] crt1e_q, crt1e_d;

  // CRTC file RAM, valid bits and read-during-write forwarding
  logic [CrtcDepth-1:0] crt_vld_q;
  logic                 ram_we;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;
  logic                 rd_vld_q;
  logic                 byp_q;
  logic [7:0]           byp_data_q;
  logic [7:0]           crt_cur;
  logic                 wr_hits_rd;

  // Result register
  logic       done_q;
  logic [7:0] rd_q, rd_d;
  logic       tchg_q, tchg_d;
  logic       schg_q, schg_d;

  logic [9:0] port_eff;
  logic [7:0] crt_v;
  logic [7:0] start_hi;
  logic [7:0] start_lo;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q   <= operation_i;
      port_q <= port_address_i;
      wdat_q <= write_data_i;
    end
  end

  svgaerb_ram #(
    .Width (8),
    .Depth (CrtcDepth)
  ) u_crtc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (crt_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (crt_idx_d),
    .rdata_o (ram_rdata)
  );

  // The RAM reads at the next CRTC index so the entry is ready for the next access
  assign wr_hits_rd = ram_we && (crt_idx_q == crt_idx_d);
  assign crt_cur    = byp_q ? byp_data_q : (rd_vld_q ? ram_rdata : 8'h00);

  always_comb begin
    port_eff = port_q;
    if (((port_q[9:4] == PortColorHi) || (port_q[9:4] == PortMonoHi)) && !misc_q[0]) begin
      port_eff = port_q ^ PortSwapXor;
    end
  end

  always_comb begin
    misc_d     = misc_q;
    seq_idx_d  = seq_idx_q;
    gfx_idx_d  = gfx_idx_q;
    seq_mode_d = seq_mode_q;
    gfx_e_d    = gfx_e_q;
    gfx_f_d    = gfx_f_q;
    crt_idx_d  = crt_idx_q;
    legacy_d   = legacy_q;
    lctl1_d    = lctl1_q;
    lctl2_d    = lctl2_q;
    nctl2_d    = nctl2_q;
    wbank_d    = wbank_q;
    rbank_d    = rbank_q;
    start_d    = start_q;
    crt08_d    = crt08_q;
    crt0c_d    = crt0c_q;
    crt0d_d    = crt0d_q;
    crt11_d    = crt11_q;
    crt1e_d    = crt1e_q;
    ram_we     = 1'b0;
    rd_d       = 8'h00;
    tchg_d     = 1'b0;
    schg_d     = 1'b0;
    start_hi   = crt0c_q;
    start_lo   = crt0d_q;

    // Protected overflow register keeps all but bit 4
    crt_v = wdat_q;
    if ((crt_idx_q == CrtIdxOverflow) && crt11_q[7]) begin
      crt_v = {crt_cur[7:5], wdat_q[4], crt_cur[3:0]};
    end
    crt_v     = crt_v & CrtcWmask[crt_idx_q];
    ram_wdata = crt_v;

    if (item_vld_q && op_q) begin
      case (port_eff)
        PortMiscW:  misc_d = wdat_q;
        PortSeqIdx: seq_idx_d = wdat_q[3:0];
        PortSeqDat: begin
          if (seq_idx_q == SeqIdxVersion) begin
            legacy_d = 1'b1;
          end else if (seq_idx_q == SeqIdxCtrlTwo) begin
            if (legacy_q) begin
              lctl2_d = wdat_q;
            end else begin
              nctl2_d = wdat_q;
              tchg_d  = 1'b1;
            end
          end else if (seq_idx_q == SeqIdxCtrlOne) begin
            if (legacy_q) begin
              lctl1_d = wdat_q;
            end else begin
              seq_mode_d = wdat_q ^ 8'h02;
              wbank_d    = {4'h0, wdat_q[3:2], ~wdat_q[1], wdat_q[0]};
            end
          end
        end
        PortGfxIdx: gfx_idx_d = wdat_q[3:0];
        PortGfxDat: begin
          if (gfx_idx_q == GfxIdxRegE) begin
            gfx_e_d = wdat_q;
            rbank_d = {4'h0, wdat_q[3:2], ~wdat_q[1], wdat_q[0]};
          end else if (gfx_idx_q == GfxIdxRegF) begin
            gfx_f_d = wdat_q;
          end
        end
        PortCrtIdx: crt_idx_d = wdat_q[CrtcIdxW-1:0];
        PortCrtDat: begin
          // Write protect drops writes to the horizontal/vertical totals group
          if (!((crt_idx_q < CrtIdxOverflow) && crt11_q[7])) begin
            ram_we = 1'b1;
            if (crt_idx_q == CrtIdxPreset)   crt08_d = crt_v;
            if (crt_idx_q == CrtIdxStartHi)  crt0c_d = crt_v;
            if (crt_idx_q == CrtIdxStartLo)  crt0d_d = crt_v;
            if (crt_idx_q == CrtIdxVrsEnd)   crt11_d = crt_v;
            if (crt_idx_q == CrtIdxModule)   crt1e_d = crt_v;
            if ((crt_v != crt_cur) &&
                ((crt_idx_q < CrtIdxCursorHi) || (crt_idx_q > CrtIdxVrsStart))) begin
              if ((crt_idx_q == CrtIdxStartHi) || (crt_idx_q == CrtIdxStartLo)) begin
                if (crt_idx_q == CrtIdxStartHi) start_hi = crt_v;
                if (crt_idx_q == CrtIdxStartLo) start_lo = crt_v;
                start_d = {1'b0, start_hi, start_lo} + {15'h0, crt08_q[6:5]};
                schg_d  = 1'b1;
              end else begin
                tchg_d = 1'b1;
              end
            end
          end
        end
        PortWrBank: if (gfx_f_q[2]) wbank_d = wdat_q;
        PortRdBank: if (gfx_f_q[2]) rbank_d = wdat_q;
        PortClkSel: begin
          if (chip_q != ChipModelNew) begin
            misc_d[3:2] = wdat_q[1:0];
            nctl2_d[0]  = wdat_q[2];
            lctl1_d[4]  = wdat_q[3];
            tchg_d      = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (item_vld_q) begin
      rd_d = ReadIdle;
      case (port_eff)
        PortMiscR:  rd_d = misc_q;
        PortSeqIdx: rd_d = {4'h0, seq_idx_q};
        PortSeqDat: begin
          if (seq_idx_q == SeqIdxVersion) begin
            legacy_d = 1'b0;
            rd_d     = chip_id(chip_q);
          end else if (seq_idx_q == SeqIdxCtrlTwo) begin
            rd_d = legacy_q ? lctl2_q : nctl2_q;
          end else if (seq_idx_q == SeqIdxCtrlOne) begin
            rd_d = legacy_q ? lctl1_q : seq_mode_q;
          end
        end
        PortGfxIdx: rd_d = {4'h0, gfx_idx_q};
        PortGfxDat: begin
          if (gfx_idx_q == GfxIdxRegE) begin
            rd_d = gfx_e_q;
          end else if (gfx_idx_q == GfxIdxRegF) begin
            rd_d = gfx_f_q;
          end
        end
        PortCrtIdx: rd_d = {2'b00, crt_idx_q};
        PortCrtDat: begin
          if (!((crt_idx_q >= CrtIdxHoleLo) && (crt_idx_q <= CrtIdxHoleHi))) begin
            rd_d = crt_cur;
          end
        end
        PortWrBank: rd_d = wbank_q;
        PortRdBank: rd_d = rbank_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q     <= ChipModelCld;
      misc_q     <= '0;
      seq_idx_q  <= '0;
      gfx_idx_q  <= '0;
      seq_mode_q <= '0;
      gfx_e_q    <= '0;
      gfx_f_q    <= '0;
      crt_idx_q  <= '0;
      legacy_q   <= 1'b0;
      lctl1_q    <= '0;
      lctl2_q    <= '0;
      nctl2_q    <= '0;
      wbank_q    <= '0;
      rbank_q    <= '0;
      start_q    <= '0;
      crt08_q    <= '0;
      crt0c_q    <= '0;
      crt0d_q    <= '0;
      crt11_q    <= '0;
      crt1e_q    <= '0;
      crt_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      byp_q      <= 1'b0;
      done_q     <= 1'b0;
      tchg_q     <= 1'b0;
      schg_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chip_q <= cfg_wdata_i;
      end
      misc_q     <= misc_d;
      seq_idx_q  <= seq_idx_d;
      gfx_idx_q  <= gfx_idx_d;
      seq_mode_q <= seq_mode_d;
      gfx_e_q    <= gfx_e_d;
      gfx_f_q    <= gfx_f_d;
      crt_idx_q  <= crt_idx_d;
      legacy_q   <= legacy_d;
      lctl1_q    <= lctl1_d;
      lctl2_q    <= lctl2_d;
      nctl2_q    <= nctl2_d;
      wbank_q    <= wbank_d;
      rbank_q    <= rbank_d;
      start_q    <= start_d;
      crt08_q    <= crt08_d;
      crt0c_q    <= crt0c_d;
      crt0d_q    <= crt0d_d;
      crt11_q    <= crt11_d;
      crt1e_q    <= crt1e_d;
      if (ram_we) begin
        crt_vld_q[crt_idx_q] <= 1'b1;
      end
      rd_vld_q <= crt_vld_q[crt_idx_d] || wr_hits_rd;
      byp_q    <= wr_hits_rd;
      done_q   <= item_vld_q;
      tchg_q   <= tchg_d;
      schg_q   <= schg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ram_wdata;
    rd_q       <= rd_d;
  end

  // Bank, start and display flags come straight from state: it only moves on a transfer
  assign done_o                = done_q;
  assign read_data_o           = rd_q;
  assign mem_wr_bank_o         = wbank_q[4:0];
  assign mem_rd_bank_o         = gfx_f_q[0] ? rbank_q[4:0] : wbank_q[4:0];
  assign start_address_o       = start_q;
  assign full_memory_display_o = crt1e_q[7];
  assign timing_changed_o      = tchg_q;
  assign start_changed_o       = schg_q;

endmodule

FILE: hw/rtl/svgaerb_chk.sv
// ----------------------------------------------------------------------------
// svgaerb_chk
// Port-level checks of the extended register banking block, bound to the top.
// ----------------------------------------------------------------------------
`include "svga_extended_register_banking_macros.svh"

module svgaerb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [7:0]  read_data_o,
  input logic        timing_changed_o,
  input logic        start_changed_o
);

  `SVGAERB_ASSERT(a_result_follows, start && !busy |-> ##2 done_o, "transfer gave no result")
  `SVGAERB_ASSERT(a_no_spurious, done_o |-> $past(start && !busy, 2), "result without transfer")
  `SVGAERB_ASSERT(a_pulse_strobe, timing_changed_o || start_changed_o |-> done_o, "pulse off strobe")
  `SVGAERB_ASSERT(a_pulse_excl, !(timing_changed_o && start_changed_o), "both change pulses set")
  `SVGAERB_ASSERT(a_read_quiet, done_o && read_data_o != 8'h00 |-> !timing_changed_o && !start_changed_o, "read pulsed")

endmodule

bind svga_extended_register_banking svgaerb_chk u_svgaerb_chk (.*);
